FILE: hdl/arpc_pkg.sv
`timescale 1ns / 1ps

package arpc_pkg;

    // Table geometry
    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    localparam int IP_W       = 32;
    localparam int MAC_W      = 48;
    localparam int TIME_W     = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Operation codes
    localparam logic [1:0] OP_LEARN   = 2'd0;
    localparam logic [1:0] OP_RESOLVE = 2'd1;
    localparam logic [1:0] OP_TICK    = 2'd2;

    // Slot states
    localparam logic [1:0] SLOT_FREE       = 2'd0;
    localparam logic [1:0] SLOT_INCOMPLETE = 2'd1;
    localparam logic [1:0] SLOT_VALID      = 2'd2;

    // Result status codes
    localparam logic [2:0] RES_LEARNED      = 3'd0;
    localparam logic [2:0] RES_LEARN_FULL   = 3'd1;
    localparam logic [2:0] RES_UNSUPPORTED  = 3'd2;
    localparam logic [2:0] RES_HIT          = 3'd3;
    localparam logic [2:0] RES_NEW_REQUEST  = 3'd4;
    localparam logic [2:0] RES_RETRY        = 3'd5;
    localparam logic [2:0] RES_WAITING      = 3'd6;
    localparam logic [2:0] RES_RESOLVE_FULL = 3'd7;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ASSIGNED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_DELAY = 2'd2;

    localparam logic [31:0] RETRY_DELAY_RESET = 32'd100;

    // ARP header values that are supported
    localparam logic [15:0] HW_ETHERNET  = 16'h0001;
    localparam logic [15:0] PROTO_IPV4   = 16'h0800;
    localparam logic [7:0]  HW_LEN_ETH   = 8'd6;
    localparam logic [7:0]  PROTO_LEN_V4 = 8'd4;
    localparam logic [15:0] OPC_REQUEST  = 16'h0001;

    typedef struct packed {
        logic [1:0]       operation;
        logic [IP_W-1:0]  sender_ip;
        logic [MAC_W-1:0] sender_mac;
        logic [IP_W-1:0]  target_ip;
        logic [15:0]      hw_type;
        logic [15:0]      proto_type;
        logic [7:0]       hw_len;
        logic [7:0]       proto_len;
        logic [15:0]      arp_opcode;
    } t_in_item;

    typedef struct packed {
        logic [2:0]       status;
        logic [MAC_W-1:0] resolved_mac;
        logic             arp_reply;
    } t_out_item;

    typedef struct packed {
        logic [IP_W-1:0]   own_ip;
        logic              own_ip_assigned;
        logic [TIME_W-1:0] retry_delay;
        logic [TIME_W-1:0] tick_count;
    } t_cfg;

    typedef struct packed {
        logic [MAC_W-1:0]  mac;
        logic [TIME_W-1:0] req_time;
    } t_slot_data;

endpackage

FILE: hdl/arpc_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one registered read port.
module arpc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/arpc_ctrl.sv
`timescale 1ns / 1ps

// Table controller: scans the address RAM, then writes the chosen slot, or, for a
// resolve hit, reads its data and may write back a new request time.
module arpc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  arpc_pkg::t_in_item i_item,
    input  arpc_pkg::t_cfg     i_cfg,
    output logic               o_idle,
    output logic               o_res_valid,
    output arpc_pkg::t_out_item o_res,
    input  logic               i_res_take
);

    localparam logic [arpc_pkg::IDX_W-1:0] LAST_IDX =
        arpc_pkg::IDX_W'(arpc_pkg::ENTRIES - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_READ,
        S_DONE
    } t_state;

    t_state r_state;

    logic [1:0] r_slot_st [arpc_pkg::ENTRIES];

    logic                          r_is_learn;
    logic                          r_reply;
    logic [arpc_pkg::IP_W-1:0]     r_sip;
    logic [arpc_pkg::MAC_W-1:0]    r_smac;

    logic [arpc_pkg::IDX_W-1:0]    r_issue_idx;
    logic                          r_issue_done;
    logic                          r_cmp_v;
    logic [arpc_pkg::IDX_W-1:0]    r_cmp_idx;
    logic [1:0]                    r_cmp_st;

    logic                          r_hit_found;
    logic [arpc_pkg::IDX_W-1:0]    r_hit_idx;
    logic [1:0]                    r_hit_st;
    logic                          r_free_found;
    logic [arpc_pkg::IDX_W-1:0]    r_free_idx;

    arpc_pkg::t_out_item           r_res;

    logic                          ip_we;
    logic [arpc_pkg::IDX_W-1:0]    ip_waddr;
    logic [arpc_pkg::IP_W-1:0]     ip_rdata;
    logic                          dat_we;
    logic [arpc_pkg::IDX_W-1:0]    dat_waddr;
    arpc_pkg::t_slot_data          dat_wdata;
    arpc_pkg::t_slot_data          dat_rdata;

    logic                          header_ok;
    logic                          reply_req;
    logic [arpc_pkg::IDX_W-1:0]    target_idx;
    logic [arpc_pkg::TIME_W-1:0]   elapsed;
    logic                          retry_due;

    assign header_ok = (i_item.hw_type == arpc_pkg::HW_ETHERNET)
                    && (i_item.proto_type == arpc_pkg::PROTO_IPV4)
                    && (i_item.hw_len == arpc_pkg::HW_LEN_ETH)
                    && (i_item.proto_len == arpc_pkg::PROTO_LEN_V4);

    assign reply_req = (i_item.target_ip == i_cfg.own_ip) && i_cfg.own_ip_assigned
                    && (i_item.arp_opcode == arpc_pkg::OPC_REQUEST);

    assign target_idx = r_hit_found ? r_hit_idx : r_free_idx;
    assign elapsed    = i_cfg.tick_count - dat_rdata.req_time;
    assign retry_due  = (elapsed >= i_cfg.retry_delay);

    always_comb begin
        ip_we     = 1'b0;
        ip_waddr  = target_idx;
        dat_we    = 1'b0;
        dat_waddr = target_idx;
        dat_wdata = '{mac: r_smac, req_time: '0};
        case (r_state)
            S_DECIDE: begin
                if (r_is_learn) begin
                    ip_we  = r_hit_found || r_free_found;
                    dat_we = r_hit_found || r_free_found;
                end else if (!r_hit_found && r_free_found) begin
                    ip_we     = 1'b1;
                    dat_we    = 1'b1;
                    dat_wdata = '{mac: '0, req_time: i_cfg.tick_count};
                end
            end
            S_READ: begin
                dat_waddr = r_hit_idx;
                dat_wdata = '{mac: dat_rdata.mac, req_time: i_cfg.tick_count};
                dat_we    = (r_hit_st != arpc_pkg::SLOT_VALID) && retry_due;
            end
            default: begin
            end
        endcase
    end

    arpc_ram #(
        .WIDTH(arpc_pkg::IP_W),
        .DEPTH(arpc_pkg::ENTRIES)
    ) u_ip_ram (
        .i_clk  (i_clk),
        .i_we   (ip_we),
        .i_waddr(ip_waddr),
        .i_wdata(r_sip),
        .i_raddr(r_issue_idx),
        .o_rdata(ip_rdata)
    );

    arpc_ram #(
        .WIDTH($bits(arpc_pkg::t_slot_data)),
        .DEPTH(arpc_pkg::ENTRIES)
    ) u_data_ram (
        .i_clk  (i_clk),
        .i_we   (dat_we),
        .i_waddr(dat_waddr),
        .i_wdata(dat_wdata),
        .i_raddr(r_hit_idx),
        .o_rdata(dat_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cmp_v <= 1'b0;
            for (int i = 0; i < arpc_pkg::ENTRIES; i++) begin
                r_slot_st[i] <= arpc_pkg::SLOT_FREE;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_is_learn   <= (i_item.operation == arpc_pkg::OP_LEARN);
                        r_reply      <= reply_req;
                        r_sip        <= i_item.sender_ip;
                        r_smac       <= i_item.sender_mac;
                        r_issue_idx  <= '0;
                        r_issue_done <= 1'b0;
                        r_cmp_v      <= 1'b0;
                        r_hit_found  <= 1'b0;
                        r_free_found <= 1'b0;
                        if ((i_item.operation == arpc_pkg::OP_LEARN) && !header_ok) begin
                            r_res   <= '{status: arpc_pkg::RES_UNSUPPORTED,
                                         resolved_mac: '0, arp_reply: 1'b0};
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    // Issue stage: one slot address per cycle.
                    if (!r_issue_done) begin
                        r_cmp_v   <= 1'b1;
                        r_cmp_idx <= r_issue_idx;
                        r_cmp_st  <= r_slot_st[r_issue_idx];
                        if (r_issue_idx == LAST_IDX) begin
                            r_issue_done <= 1'b1;
                        end else begin
                            r_issue_idx <= r_issue_idx + arpc_pkg::IDX_W'(1);
                        end
                    end else begin
                        r_cmp_v <= 1'b0;
                    end
                    // Compare stage: the RAM data for r_cmp_idx is now present.
                    if (r_cmp_v) begin
                        if (r_cmp_st == arpc_pkg::SLOT_FREE) begin
                            if (!r_free_found) begin
                                r_free_found <= 1'b1;
                                r_free_idx   <= r_cmp_idx;
                            end
                        end else if (!r_hit_found && (ip_rdata == r_sip)) begin
                            r_hit_found <= 1'b1;
                            r_hit_idx   <= r_cmp_idx;
                            r_hit_st    <= r_cmp_st;
                        end
                        if (r_cmp_idx == LAST_IDX) begin
                            r_state <= S_DECIDE;
                        end
                    end
                end
                S_DECIDE: begin
                    r_cmp_v <= 1'b0;
                    if (r_is_learn) begin
                        if (r_hit_found || r_free_found) begin
                            r_slot_st[target_idx] <= arpc_pkg::SLOT_VALID;
                            r_res.status <= arpc_pkg::RES_LEARNED;
                        end else begin
                            r_res.status <= arpc_pkg::RES_LEARN_FULL;
                        end
                        r_res.resolved_mac <= '0;
                        r_res.arp_reply    <= r_reply;
                        r_state            <= S_DONE;
                    end else if (r_hit_found) begin
                        r_state <= S_READ;
                    end else begin
                        if (r_free_found) begin
                            r_slot_st[r_free_idx] <= arpc_pkg::SLOT_INCOMPLETE;
                            r_res.status <= arpc_pkg::RES_NEW_REQUEST;
                        end else begin
                            r_res.status <= arpc_pkg::RES_RESOLVE_FULL;
                        end
                        r_res.resolved_mac <= '0;
                        r_res.arp_reply    <= 1'b0;
                        r_state            <= S_DONE;
                    end
                end
                S_READ: begin
                    r_res.arp_reply <= 1'b0;
                    if (r_hit_st == arpc_pkg::SLOT_VALID) begin
                        r_res.status       <= arpc_pkg::RES_HIT;
                        r_res.resolved_mac <= dat_rdata.mac;
                    end else begin
                        r_res.status <= retry_due ? arpc_pkg::RES_RETRY
                                                  : arpc_pkg::RES_WAITING;
                        r_res.resolved_mac <= '0;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (i_res_take) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_idle      = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

endmodule

FILE: hdl/arp_cache_resolver.sv
`timescale 1ns / 1ps
// Timing: a learn or resolve result waits on the scan of all ENTRIES slots; a resolve hit adds
// a data RAM read, and an unsupported header skips the scan. A new transaction, a tick
// included, is accepted only while the controller is idle, that is once it has handed its
// last result to the output register.
// Reset (synchronous, active low) marks every slot free at once, zeroes the tick counter
// and restores the configuration defaults; slot contents in RAM are left as they are.

// ARP cache and resolver for Ethernet/IPv4.
//
// The table state is held in two synchronous RAMs: one with the IPv4 address of
// each slot, one with the MAC and the tick of the last request. The slot states
// (free, incomplete, valid) are kept in flip-flops so that reset can free the
// whole table at once; the RAM words of a free slot are never looked at, so they
// need no clearing.
//
// A learn or resolve transaction walks the address RAM one slot per cycle. The
// lowest non-free slot with the same address is the hit, and the lowest free
// slot is remembered as the place for a new entry. The controller then writes
// the chosen slot, or, for a resolve hit, reads the MAC and request time and
// decides between a hit, a retry and waiting. Only one transaction is inside
// the controller at a time, so no two accesses to a slot can overlap.
//
// Finished results go to an output register, so the controller can take the
// next transaction while an earlier result still waits to be collected.
module arp_cache_resolver (
    input  logic                               i_clk,
    input  logic                               i_rst_n,

    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  arpc_pkg::t_in_item                 i_in_data,

    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output arpc_pkg::t_out_item                o_out_data,

    input  logic                               i_cfg_we,
    input  logic [arpc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [arpc_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);

    // Configuration registers and the tick counter, which counts accepted tick transactions.
    logic [arpc_pkg::IP_W-1:0]   r_own_ip;
    logic                        r_own_assigned;
    logic [arpc_pkg::TIME_W-1:0] r_retry_delay;
    logic [arpc_pkg::TIME_W-1:0] r_tick;

    // Output register.
    logic                        r_out_valid;
    arpc_pkg::t_out_item         r_out_data;

    logic                        ctrl_idle;
    logic                        ctrl_res_valid;
    arpc_pkg::t_out_item         ctrl_res;
    logic                        res_take;
    logic                        in_accept;
    logic                        start;
    arpc_pkg::t_cfg              cfg;

    assign in_accept = i_in_valid && o_in_ready;

    // Only learn and resolve transactions involve the table; a tick is handled
    // here and the unused operation code is simply consumed.
    assign start = in_accept && ((i_in_data.operation == arpc_pkg::OP_LEARN)
                              || (i_in_data.operation == arpc_pkg::OP_RESOLVE));

    // The controller's result moves across when the output register is empty
    // or is being emptied in this same cycle.
    assign res_take = ctrl_res_valid && (!r_out_valid || i_out_ready);

    assign cfg = '{own_ip: r_own_ip, own_ip_assigned: r_own_assigned,
                   retry_delay: r_retry_delay, tick_count: r_tick};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_ip       <= '0;
            r_own_assigned <= 1'b0;
            r_retry_delay  <= arpc_pkg::RETRY_DELAY_RESET;
            r_tick         <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    arpc_pkg::CFG_OWN_IP:       r_own_ip       <= i_cfg_wdata;
                    arpc_pkg::CFG_OWN_ASSIGNED: r_own_assigned <= i_cfg_wdata[0];
                    arpc_pkg::CFG_RETRY_DELAY:  r_retry_delay  <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end

            if (in_accept && (i_in_data.operation == arpc_pkg::OP_TICK)) begin
                r_tick <= r_tick + arpc_pkg::TIME_W'(1);
            end

            if (res_take) begin
                r_out_valid <= 1'b1;
                r_out_data  <= ctrl_res;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    arpc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_item     (i_in_data),
        .i_cfg      (cfg),
        .o_idle     (ctrl_idle),
        .o_res_valid(ctrl_res_valid),
        .o_res      (ctrl_res),
        .i_res_take (res_take)
    );

    assign o_in_ready  = ctrl_idle;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

FILE: test/arp_answer_checker.sv
`timescale 1ns / 1ps

// Watches both channels and the register port of the ARP cache, keeps its own
// copy of the table, and compares every result with the answer it worked out.
module arp_answer_checker
    import arpc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  t_in_item              i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  t_out_item             i_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output int                    o_mismatches,
    output int                    o_outstanding
);

    logic [1:0]        tbl_state [ENTRIES];
    logic [IP_W-1:0]   tbl_ip    [ENTRIES];
    logic [MAC_W-1:0]  tbl_mac   [ENTRIES];
    logic [TIME_W-1:0] tbl_asked [ENTRIES];
    logic [TIME_W-1:0] ticks;

    logic [IP_W-1:0]   own_addr;
    logic              own_assigned;
    logic [TIME_W-1:0] retry_ticks;

    t_out_item answers_due [$];
    int        mismatch_total = 0;

    assign o_mismatches = mismatch_total;

    task automatic report_mismatch(input string what, input logic [63:0] seen,
                                   input logic [63:0] wanted);
        mismatch_total++;
        $display("%0t ns: mismatch in %s: got %h, expected %h", $time, what, seen, wanted);
    endtask

    // Applies one accepted transaction to the table copy; returns 1 when the
    // transaction produces a result, which is then placed in answer.
    function automatic bit cache_answer(input t_in_item item, output t_out_item answer);
        int                hit_idx;
        int                free_idx;
        int                slot;
        int                i;
        logic [TIME_W-1:0] elapsed;
        answer   = '0;
        hit_idx  = -1;
        free_idx = -1;
        if (item.operation == OP_TICK) begin
            ticks = ticks + TIME_W'(1);
            return 1'b0;
        end
        if (item.operation != OP_LEARN && item.operation != OP_RESOLVE) begin
            return 1'b0;
        end
        if (item.operation == OP_LEARN &&
            (item.hw_type != HW_ETHERNET || item.proto_type != PROTO_IPV4 ||
             item.hw_len != HW_LEN_ETH || item.proto_len != PROTO_LEN_V4)) begin
            answer.status = RES_UNSUPPORTED;
            return 1'b1;
        end
        for (i = 0; i < ENTRIES; i++) begin
            if (tbl_state[i] == SLOT_FREE) begin
                if (free_idx < 0) free_idx = i;
            end else if (hit_idx < 0 && tbl_ip[i] == item.sender_ip) begin
                hit_idx = i;
            end
        end
        if (item.operation == OP_LEARN) begin
            slot = (hit_idx >= 0) ? hit_idx : free_idx;
            if (slot < 0) begin
                answer.status = RES_LEARN_FULL;
            end else begin
                tbl_state[slot] = SLOT_VALID;
                tbl_ip[slot]    = item.sender_ip;
                tbl_mac[slot]   = item.sender_mac;
                tbl_asked[slot] = '0;
                answer.status   = RES_LEARNED;
            end
            answer.arp_reply = (item.target_ip == own_addr) && own_assigned &&
                               (item.arp_opcode == OPC_REQUEST);
        end else if (hit_idx >= 0) begin
            if (tbl_state[hit_idx] == SLOT_VALID) begin
                answer.status       = RES_HIT;
                answer.resolved_mac = tbl_mac[hit_idx];
            end else begin
                elapsed = ticks - tbl_asked[hit_idx];
                if (elapsed < retry_ticks) begin
                    answer.status = RES_WAITING;
                end else begin
                    answer.status      = RES_RETRY;
                    tbl_asked[hit_idx] = ticks;
                end
            end
        end else if (free_idx >= 0) begin
            tbl_state[free_idx] = SLOT_INCOMPLETE;
            tbl_ip[free_idx]    = item.sender_ip;
            tbl_mac[free_idx]   = '0;
            tbl_asked[free_idx] = ticks;
            answer.status       = RES_NEW_REQUEST;
        end else begin
            answer.status = RES_RESOLVE_FULL;
        end
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_item fresh;
        t_out_item oldest;
        int        i;
        if (!i_rst_n) begin
            for (i = 0; i < ENTRIES; i++) begin
                tbl_state[i] = SLOT_FREE;
                tbl_ip[i]    = '0;
                tbl_mac[i]   = '0;
                tbl_asked[i] = '0;
            end
            ticks        = '0;
            own_addr     = '0;
            own_assigned = 1'b0;
            retry_ticks  = RETRY_DELAY_RESET;
            answers_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_OWN_IP:       own_addr     = i_cfg_wdata;
                    CFG_OWN_ASSIGNED: own_assigned = i_cfg_wdata[0];
                    CFG_RETRY_DELAY:  retry_ticks  = i_cfg_wdata;
                    default: ;
                endcase
            end
            // Results are matched before new transactions are predicted, so a
            // stray result can never pair with a transaction of the same edge.
            if (i_out_valid && i_out_ready) begin
                if (answers_due.size() == 0) begin
                    report_mismatch("result with no transaction waiting for it",
                                    64'(i_out_data), '0);
                end else begin
                    oldest = answers_due.pop_front();
                    if (i_out_data.status !== oldest.status)
                        report_mismatch("status", 64'(i_out_data.status),
                                        64'(oldest.status));
                    if (i_out_data.resolved_mac !== oldest.resolved_mac)
                        report_mismatch("resolved_mac", 64'(i_out_data.resolved_mac),
                                        64'(oldest.resolved_mac));
                    if (i_out_data.arp_reply !== oldest.arp_reply)
                        report_mismatch("arp_reply", 64'(i_out_data.arp_reply),
                                        64'(oldest.arp_reply));
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (cache_answer(i_in_data, fresh)) answers_due.push_back(fresh);
            end
        end
        o_outstanding <= answers_due.size();
    end

endmodule

FILE: test/tb_arp_cache_resolver.sv
`timescale 1ns / 1ps

// Top level of the ARP cache test. This module only produces stimulus and gives
// the verdict; the checker beside the block predicts every result and counts
// any disagreement.
//
// The run starts with a short directed part that exercises the address and MAC
// extremes, every way a header can be rejected, the reply flag, and the whole
// life of an incomplete entry (new request, waiting, retry after the delay,
// and finally being learned). After that come seven random phases, each with
// its own register setting. Addresses are drawn mostly from two small pools so
// that hits, updates, waiting and retries keep happening: one pool is learned
// and resolved, the other is only ever resolved, so its entries stay incomplete
// for the whole run. Stray random addresses fill the remaining slots, after
// which the learn full and resolve full answers appear as well.
module tb_arp_cache_resolver;
    import arpc_pkg::*;

    // Operation code that the block must ignore, and the ARP reply opcode.
    localparam logic [1:0]  OP_UNUSED       = 2'd3;
    localparam logic [15:0] OPC_REPLY       = 16'h0002;
    localparam logic [31:0] DIRECTED_OWN_IP = 32'hC0A8_0001;

    // The margin below lets a transaction still inside the block run out after
    // the last expected result has been collected.
    localparam int RESULT_DRAIN   = 40;
    localparam int DRAIN_LIMIT    = 5000;
    localparam int LONG_HOLD      = 400;
    localparam int PHASES         = 7;
    localparam int PHASE_ITEMS    = 205;
    localparam int BURST_ITEMS    = 12;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    t_in_item              in_item   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             out_item;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_OWN_IP;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int fail_count;
    int answers_pending;

    // Stimulus state shared between the processes below.
    logic [IP_W-1:0] shared_pool  [6];
    logic [IP_W-1:0] request_pool [4];
    logic [IP_W-1:0] cur_own_ip   = '0;
    bit              stray_ok     = 1'b0;
    bit              no_idle      = 1'b0;
    int              hold_serial  = 0;

    arp_cache_resolver uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    arp_answer_checker answer_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_data     (in_item),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_data    (out_item),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_wdata   (cfg_wdata),
        .o_mismatches  (fail_count),
        .o_outstanding (answers_pending)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    // Idle gaps are mostly short, with an occasional long one. During a quiet
    // phase neither side idles at all.
    function automatic int idle_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_idle)   return 0;
        if (roll < 40) return 0;
        if (roll < 85) return $urandom_range(1, 4);
        if (roll < 97) return $urandom_range(5, 20);
        return $urandom_range(30, 120);
    endfunction

    // Every field random, so that fields which the operation does not use
    // still see both values on every bit.
    function automatic t_in_item filler_item();
        t_in_item item;
        item.operation  = 2'($urandom);
        item.sender_ip  = $urandom;
        item.sender_mac = {16'($urandom), 32'($urandom)};
        item.target_ip  = $urandom;
        item.hw_type    = 16'($urandom);
        item.proto_type = 16'($urandom);
        item.hw_len     = 8'($urandom);
        item.proto_len  = 8'($urandom);
        item.arp_opcode = 16'($urandom);
        return item;
    endfunction

    // A learn transaction with a supported Ethernet/IPv4 header.
    function automatic t_in_item make_learn(input logic [IP_W-1:0] sip,
                                            input logic [MAC_W-1:0] smac,
                                            input logic [IP_W-1:0] tip,
                                            input logic [15:0] opc);
        t_in_item item;
        item.operation  = OP_LEARN;
        item.sender_ip  = sip;
        item.sender_mac = smac;
        item.target_ip  = tip;
        item.hw_type    = HW_ETHERNET;
        item.proto_type = PROTO_IPV4;
        item.hw_len     = HW_LEN_ETH;
        item.proto_len  = PROTO_LEN_V4;
        item.arp_opcode = opc;
        return item;
    endfunction

    function automatic t_in_item make_resolve(input logic [IP_W-1:0] sip);
        t_in_item item;
        item           = filler_item();
        item.operation = OP_RESOLVE;
        item.sender_ip = sip;
        return item;
    endfunction

    // The request pool is never learned, so its entries stay incomplete and
    // keep giving waiting and retry answers. Stray addresses only appear once
    // the pools have had the chance to take their slots.
    function automatic logic [IP_W-1:0] pick_address(input bit for_resolve);
        int roll;
        roll = $urandom_range(0, 99);
        if (stray_ok && roll < 12)     return $urandom;
        if (for_resolve && roll >= 60) return request_pool[$urandom_range(0, 3)];
        return shared_pool[$urandom_range(0, 5)];
    endfunction

    function automatic t_in_item random_item();
        t_in_item item;
        int       roll;
        item = filler_item();
        roll = $urandom_range(0, 99);
        if (roll < 20) begin
            item.operation = OP_TICK;
        end else if (roll < 22) begin
            item.operation = OP_UNUSED;
        end else if (roll < 57) begin
            item = make_learn(pick_address(1'b0), item.sender_mac, item.target_ip,
                              item.arp_opcode);
            if ($urandom_range(0, 99) < 40) item.target_ip = cur_own_ip;
            roll = $urandom_range(0, 99);
            if (roll < 60)      item.arp_opcode = OPC_REQUEST;
            else if (roll < 90) item.arp_opcode = OPC_REPLY;
            // A broken header: one field is replaced by a random value.
            if ($urandom_range(0, 99) < 15) begin
                case ($urandom_range(0, 3))
                    0:       item.hw_type    = 16'($urandom);
                    1:       item.proto_type = 16'($urandom);
                    2:       item.hw_len     = 8'($urandom);
                    default: item.proto_len  = 8'($urandom);
                endcase
            end
        end else begin
            item = make_resolve(pick_address(1'b1));
        end
        return item;
    endfunction

    // Offers one transaction and returns at the edge at which it is taken.
    // Valid stays high after acceptance unless a gap follows, so that it is
    // never lowered and raised within the same time step.
    task automatic send_item(input t_in_item item);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Waits until every predicted result has been collected, then lets a tick
    // or an ignored transaction still inside the block run out before the
    // registers may be touched.
    task automatic wait_until_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (answers_pending != 0) @(posedge clk);
        repeat (RESULT_DRAIN) @(posedge clk);
    endtask

    task automatic apply_setting(input logic [IP_W-1:0] own, input bit assigned,
                                 input logic [TIME_W-1:0] delay);
        cur_own_ip = own;
        write_register(CFG_OWN_IP, own);
        write_register(CFG_OWN_ASSIGNED, CFG_DATA_W'(assigned));
        write_register(CFG_RETRY_DELAY, delay);
    endtask

    // Receiver: ready is high for a random stretch, then drops for a gap. When
    // the stimulus asks for it, ready is held low for a long stretch so that
    // the block fills up and has to refuse new transactions.
    initial begin : receiver
        int seen_hold;
        int gap;
        seen_hold = 0;
        forever begin
            if (hold_serial != seen_hold) begin
                seen_hold = hold_serial;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end else begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                gap = idle_gap();
                if (gap > 0) begin
                    out_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    end

    initial begin : stimulus
        t_in_item probe;
        int       phase;
        int       sent;
        int       drain_cycles;
        int       k;

        for (k = 0; k < 6; k++) shared_pool[k] = $urandom;
        for (k = 0; k < 4; k++) request_pool[k] = $urandom;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (5) @(posedge clk);

        // Directed part. A short retry delay lets the incomplete entry be
        // retried after only a couple of ticks.
        apply_setting(DIRECTED_OWN_IP, 1'b1, 32'd2);

        // Extremes of address and MAC, with and without a reply being asked.
        send_item(make_learn(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, DIRECTED_OWN_IP,
                             OPC_REQUEST));
        send_item(make_learn(32'h0000_0000, 48'h0, DIRECTED_OWN_IP, OPC_REPLY));
        send_item(make_learn(32'h0000_0000, 48'h0000_0000_0001, 32'hC0A8_0002,
                             OPC_REQUEST));
        send_item(make_resolve(32'hFFFF_FFFF));
        send_item(make_resolve(32'h0000_0000));

        // Each header field out of range in turn; the reply must stay low even
        // though the request is addressed to us.
        probe = make_learn(32'h0A00_0002, 48'h0, DIRECTED_OWN_IP, OPC_REQUEST);
        probe.hw_type = 16'h0000;
        send_item(probe);
        probe.hw_type = 16'hFFFF;
        send_item(probe);
        probe.hw_type    = HW_ETHERNET;
        probe.proto_type = 16'h0806;
        send_item(probe);
        probe.proto_type = PROTO_IPV4;
        probe.hw_len     = 8'hFF;
        send_item(probe);
        probe.hw_len    = HW_LEN_ETH;
        probe.proto_len = 8'h00;
        send_item(probe);

        // Life of an incomplete entry: new request, waiting, retry once the
        // delay has passed, waiting again, and then learned.
        send_item(make_resolve(32'h0A00_0001));
        send_item(make_resolve(32'h0A00_0001));
        probe = filler_item();
        probe.operation = OP_TICK;
        send_item(probe);
        send_item(probe);
        send_item(make_resolve(32'h0A00_0001));
        send_item(make_resolve(32'h0A00_0001));
        probe = make_resolve(32'h0A00_0001);
        probe.operation = OP_UNUSED;
        send_item(probe);
        send_item(make_learn(32'h0A00_0001, 48'h0123_4567_89AB, DIRECTED_OWN_IP,
                             16'hFFFF));
        send_item(make_resolve(32'h0A00_0001));

        // Updating a valid entry replaces its MAC.
        send_item(make_learn(32'hFFFF_FFFF, 48'h8000_0000_0000, 32'h0000_0000,
                             OPC_REQUEST));
        send_item(make_resolve(32'hFFFF_FFFF));
        wait_until_idle();

        // Random phases, each with its own register setting.
        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: apply_setting($urandom, 1'b1, 32'd1);
                1: apply_setting(32'hFFFF_FFFF, 1'b1, 32'd0);
                2: apply_setting(32'h0000_0000, 1'b1, 32'd3);
                3: apply_setting($urandom, 1'b0, 32'd5);
                4: apply_setting($urandom, 1'b1, 32'hFFFF_FFFF);
                5: apply_setting($urandom, 1'b1, RETRY_DELAY_RESET);
                default: apply_setting($urandom, 1'b1, $urandom_range(2, 8));
            endcase
            stray_ok = (phase != 0);
            no_idle  = (phase == 2);

            if (phase == 3) begin
                // Long receiver hold-off while the sender keeps offering
                // back-to-back transactions that all produce results.
                no_idle = 1'b1;
                hold_serial++;
                for (k = 0; k < BURST_ITEMS; k++) begin
                    do probe = random_item();
                    while (probe.operation != OP_LEARN && probe.operation != OP_RESOLVE);
                    send_item(probe);
                end
                no_idle = 1'b0;
            end

            sent = 0;
            while (sent < PHASE_ITEMS) begin
                probe = random_item();
                send_item(probe);
                if (probe.operation != OP_UNUSED) sent++;
            end
            no_idle = 1'b0;
            wait_until_idle();
        end

        // Final drain with a bound of its own; anything still expected after
        // it counts as a failure.
        drain_cycles = 0;
        @(posedge clk);
        while (answers_pending != 0 && drain_cycles < DRAIN_LIMIT) begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (RESULT_DRAIN) @(posedge clk);

        if (fail_count == 0 && answers_pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog well beyond the slowest correct run.
    initial begin : watchdog
        #3_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/arpc_pkg.sv
hdl/arpc_ram.sv
hdl/arpc_ctrl.sv
hdl/arp_cache_resolver.sv
test/arp_answer_checker.sv
test/tb_arp_cache_resolver.sv
